>>> rtl/core/sha_pkg.sv
// SHA-256 engine package: round constants, initial hash, a rotate helper function,
// and the front-to-back command type. No dependencies.
`default_nettype none
package sha_pkg;
  localparam int unsigned MaxMsgBytes = 536870911;
  localparam logic [7:0] PadByte = 8'h80;

  typedef enum logic [1:0] {
    CMD_BLOCK = 2'd0,
    CMD_FINAL = 2'd1,
    CMD_LONG  = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t     kind;
    logic [511:0]  block;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE  = 2'd0,
    BK_ROUND = 2'd1,
    BK_ADD   = 2'd2,
    BK_OUT   = 2'd3
  } bk_state_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction
endpackage
`default_nettype wire

>>> rtl/core/sha256_hash_engine.sv
// SHA-256 hash engine top level: front end, command queue, compression core.
// Depends on sha_pkg, sha_front, sha_queue, sha_back.
//
// Input stream: one byte per transfer, with a byte-valid flag and tlast for
// the end of the message (tlast with byte-valid 0 ends without a byte).
// Bytes enter at one per cycle until a block fills; the front end then waits
// for queue space. Each 64-byte block passes through the round core as load,
// 64 rounds and chaining add; the core takes the next block only after the
// chaining add, so a long message backs up into the two-entry queue.
// Output stream: eight digest words, word 0 first, tlast on word 7; a too-long
// message gives one transfer with the flag set and data 0.
// Word 0 follows the chaining add of the final block; when the padding needs a
// second block, both blocks pass through the core first.
// Reset clears all control and loads the initial hash. A stalled receiver
// holds the current word; the core and then the queue and front end fill up.
`default_nettype none
module sha256_hash_engine import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // message_byte
  input  wire logic        in_tuser,   // byte_valid
  input  wire logic        in_tlast,   // last_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // digest_word, word_index, zero fill
  output logic             out_tuser,  // too_long
  output logic             out_tlast   // last_word
);
  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t        fq_cmd, qb_cmd;
  logic [31:0] word;
  logic [2:0]  idx;

  sha_front u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_byte(in_tdata),
    .in_bvalid(in_tuser), .in_last(in_tlast),
    .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd(fq_cmd)
  );

  sha_queue u_queue (
    .clk, .rst_n, .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_cmd),
    .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_cmd)
  );

  sha_back u_back (
    .clk, .rst_n, .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd(qb_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_word(word),
    .out_index(idx), .out_last(out_tlast), .out_long(out_tuser)
  );

  assign out_tdata = {5'd0, idx, word};
endmodule
`default_nettype wire

>>> rtl/core/sha_front.sv
// SHA-256 front end: packs message bytes into 512-bit blocks and builds
// padding blocks. Depends on sha_pkg.
`default_nettype none
module sha_front import sha_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_bvalid,
  input  wire logic       in_last,
  output logic            cmd_valid,
  input  wire logic       cmd_ready,
  output cmd_t            cmd
);
  logic [511:0] blk_r, blk_nxt;
  logic [29:0]  cnt_r, cnt_nxt;
  logic         ovf_r, ovf_nxt;
  logic         pend_r, pend_nxt;
  logic         pend2_r, pend2_nxt;
  logic         cv_r, cv_nxt;
  cmd_t         cmd_r, cmd_nxt;
  logic [5:0]   pos;
  logic [9:0]   sh;

  assign in_ready  = !cv_r && !pend_r;
  assign cmd_valid = cv_r;
  assign cmd       = cmd_r;
  assign pos       = cnt_r[5:0];
  assign sh        = {4'd0, pos} << 3;

  always_comb begin
    logic [511:0] b;
    logic [5:0]   p;
    blk_nxt = blk_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r;
    pend_nxt = pend_r; pend2_nxt = pend2_r;
    cv_nxt = cv_r; cmd_nxt = cmd_r;
    b = blk_r; p = pos;
    if (cv_r && cmd_ready) cv_nxt = 1'b0;
    if (pend_r && !cv_r) begin
      // emit final block with length, or second padding block
      b = pend2_r ? 512'd0 : blk_r;
      b[31:0] = {cnt_r[28:0], 3'd0};
      cmd_nxt.kind = CMD_FINAL; cmd_nxt.block = b;
      cv_nxt = 1'b1; pend_nxt = 1'b0; pend2_nxt = 1'b0;
      cnt_nxt = '0; ovf_nxt = 1'b0;
    end else if (in_valid && in_ready) begin
      if (in_bvalid && !ovf_r) begin
        if (cnt_r >= 30'(MaxMsgBytes)) ovf_nxt = 1'b1;
        else begin
          b = blk_r;
          b[511 - sh -: 8] = in_byte;
          if (pos == 6'd0) b[503:0] = '0;
          cnt_nxt = cnt_r + 30'd1;
          p = pos + 6'd1;
          if (p == 6'd0) begin
            cmd_nxt.kind = CMD_BLOCK; cmd_nxt.block = b; cv_nxt = 1'b1;
          end
        end
      end
      blk_nxt = b;
      if (in_last) begin
        if (ovf_nxt) begin
          cmd_nxt.kind = CMD_LONG; cmd_nxt.block = '0; cv_nxt = 1'b1;
          cnt_nxt = '0; ovf_nxt = 1'b0;
        end else begin
          if (p == 6'd0) b = '0;
          b[511 - ({4'd0, p} << 3) -: 8] = PadByte;
          for (int i = 0; i < 64; i++)
            if (6'(i) > p) b[511 - 8*i -: 8] = 8'd0;
          blk_nxt = b;
          pend_nxt = 1'b1;
          if (p >= 6'd56) begin
            // padding spills: queue this block, length goes in the next
            pend2_nxt = 1'b1;
            if (p != 6'd0 || cnt_nxt == cnt_r) begin
              cmd_nxt.kind = CMD_BLOCK; cmd_nxt.block = b; cv_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    blk_r <= blk_nxt; cmd_r <= cmd_nxt;
    if (!rst_n) begin
      cnt_r <= '0; ovf_r <= 1'b0; pend_r <= 1'b0; pend2_r <= 1'b0; cv_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; ovf_r <= ovf_nxt; pend_r <= pend_nxt;
      pend2_r <= pend2_nxt; cv_r <= cv_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sha_queue.sv
// Two-entry command queue between front end and compression core.
// Depends on sha_pkg.
`default_nettype none
module sha_queue import sha_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic wr_valid,
  output logic      wr_ready,
  input  cmd_t      wr_data,
  output logic      rd_valid,
  input  wire logic rd_ready,
  output cmd_t      rd_data
);
  cmd_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       do_wr, do_rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= !wp_r;
      if (do_rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(do_wr) - 2'(do_rd);
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/sha_back.sv
// SHA-256 compression core: one round per cycle, chaining update and
// digest word output. Depends on sha_pkg.
`default_nettype none
module sha_back import sha_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  cmd_t             cmd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_word,
  output logic [2:0]       out_index,
  output logic             out_last,
  output logic             out_long
);
  bk_state_t   st_r, st_nxt;
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [31:0] w_r [16];
  logic [5:0]  rnd_r;
  logic        fin_r, lng_r;
  logic [2:0]  idx_r;
  logic [31:0] s0, s1, t1, t2;

  assign cmd_ready = st_r == BK_IDLE;
  assign out_valid = st_r == BK_OUT;
  assign out_word  = lng_r ? 32'd0 : h_r[idx_r];
  assign out_index = idx_r;
  assign out_last  = lng_r || idx_r == 3'd7;
  assign out_long  = lng_r;

  always_comb begin
    s0 = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1 = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    t1 = v_r[7] + (rotr(v_r[4], 6) ^ rotr(v_r[4], 11) ^ rotr(v_r[4], 25))
       + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6])) + RoundK[rnd_r] + w_r[0];
    t2 = (rotr(v_r[0], 2) ^ rotr(v_r[0], 13) ^ rotr(v_r[0], 22))
       + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      BK_IDLE:  if (cmd_valid) st_nxt = cmd.kind == CMD_LONG ? BK_OUT : BK_ROUND;
      BK_ROUND: if (rnd_r == 6'd63) st_nxt = BK_ADD;
      BK_ADD:   st_nxt = fin_r ? BK_OUT : BK_IDLE;
      BK_OUT:   if (out_ready && out_last) st_nxt = BK_IDLE;
      default:  st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      BK_IDLE: if (cmd_valid) begin
        for (int i = 0; i < 16; i++) w_r[i] <= cmd.block[511 - 32*i -: 32];
        for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        fin_r <= cmd.kind == CMD_FINAL;
        lng_r <= cmd.kind == CMD_LONG;
      end
      BK_ROUND: begin
        // rolling window: w_r[0] is W[t]
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= s1 + w_r[9] + s0 + w_r[0];
        for (int i = 1; i < 8; i++) if (i != 4) v_r[i] <= v_r[i-1];
        v_r[4] <= v_r[3] + t1;
        v_r[0] <= t1 + t2;
      end
      default: ;
    endcase
    if (!rst_n) begin
      st_r <= BK_IDLE; rnd_r <= '0; idx_r <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
    end else begin
      st_r <= st_nxt;
      if (st_r == BK_ROUND) rnd_r <= rnd_r + 6'd1;
      if (st_r == BK_ADD) for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      if (st_r == BK_OUT && out_ready) begin
        idx_r <= idx_r + 3'd1;
        if (out_last) begin
          idx_r <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= InitHash[i];
        end
      end
    end
  end
endmodule
`default_nettype wire
